// ----- rtl/gdad_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian date adder package
// Field widths, status codes, datapath operations and calendar helper
// functions shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int MaxYear = 9999;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int OffW   = 17;
  localparam int StatW  = 2;
  localparam int ModW   = 9;   // year modulo 400
  localparam int DoyW   = 9;   // day of year and year length
  localparam int AccW   = 18;  // signed day count during an add

  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  // Bit positions inside in_tdata and out_tdata
  localparam int YearLo  = 0;
  localparam int MonthLo = YearLo + YearW;
  localparam int DayLo   = MonthLo + MonthW;
  localparam int OffLo   = DayLo + DayW;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD_START,
    OP_MOD_STEP,
    OP_LOAD_END,
    OP_ADD_START,
    OP_YEAR_STEP,
    OP_MARK_ERR,
    OP_MONTH_STEP
  } dp_op_t;

  // The add result is committed by its own operation; kept apart so that the
  // operation enum stays within three bits.
  typedef struct packed {
    dp_op_t op;
    logic   add_end;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic year_done;
    logic year_err;
    logic month_done;
  } dp_stat_t;

  // Leap year test on the year taken modulo 400.
  function automatic logic is_leap(input logic [ModW-1:0] m400);
    is_leap = (m400 == '0) ||
              ((m400 != ModW'(100)) && (m400 != ModW'(200)) &&
               (m400 != ModW'(300)) && (m400[1:0] == 2'b00));
  endfunction

  function automatic logic [DoyW-1:0] year_len(input logic leap);
    year_len = leap ? DoyW'(366) : DoyW'(365);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    case (m)
      4'd2:                      month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_len = 5'd30;
      default:                   month_len = 5'd31;
    endcase
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [DoyW-1:0] days_before_month(input logic [MonthW-1:0] m);
    case (m)
      4'd2:    days_before_month = 9'd31;
      4'd3:    days_before_month = 9'd59;
      4'd4:    days_before_month = 9'd90;
      4'd5:    days_before_month = 9'd120;
      4'd6:    days_before_month = 9'd151;
      4'd7:    days_before_month = 9'd181;
      4'd8:    days_before_month = 9'd212;
      4'd9:    days_before_month = 9'd243;
      4'd10:   days_before_month = 9'd273;
      4'd11:   days_before_month = 9'd304;
      4'd12:   days_before_month = 9'd334;
      default: days_before_month = 9'd0;
    endcase
  endfunction

endpackage

// ----- rtl/gdad_ctrl.sv -----
// ----------------------------------------------------------------------------
// Gregorian date adder controller
// Sequences load validation and the year and month walks of an add, and owns
// the input and result handshakes.
// ----------------------------------------------------------------------------
module gdad_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_action,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  gdad_pkg::dp_stat_t stat,
  output gdad_pkg::dp_cmd_t  cmd
);
  import gdad_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_MOD,
    S_LD_END,
    S_ADD_YEAR,
    S_ADD_MONTH,
    S_ADD_END
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd.op        = OP_NONE;
    cmd.add_end   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = in_action ? OP_ADD_START : OP_LOAD_START;
          state_nxt = in_action ? S_ADD_YEAR : S_LD_MOD;
        end
      end
      S_LD_MOD: begin
        if (stat.mod_done) begin
          state_nxt = S_LD_END;
        end else begin
          cmd.op = OP_MOD_STEP;
        end
      end
      S_LD_END: begin
        if (out_free) begin
          cmd.op        = OP_LOAD_END;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ADD_YEAR: begin
        if (stat.year_err) begin
          cmd.op    = OP_MARK_ERR;
          state_nxt = S_ADD_END;
        end else if (stat.year_done) begin
          state_nxt = S_ADD_MONTH;
        end else begin
          cmd.op = OP_YEAR_STEP;
        end
      end
      S_ADD_MONTH: begin
        if (stat.month_done) begin
          state_nxt = S_ADD_END;
        end else begin
          cmd.op = OP_MONTH_STEP;
        end
      end
      S_ADD_END: begin
        if (out_free) begin
          cmd.add_end   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/gdad_dpath.sv -----
// ----------------------------------------------------------------------------
// Gregorian date adder datapath
// Holds the stored date with its year modulo 400, the working registers of a
// load or an add, and the result register.
// ----------------------------------------------------------------------------
module gdad_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [gdad_pkg::InDataW-1:0]  in_data,
  input  gdad_pkg::dp_cmd_t             cmd,
  output gdad_pkg::dp_stat_t            stat,
  output logic [gdad_pkg::OutDataW-1:0] out_data,
  output logic [gdad_pkg::StatW-1:0]    out_status
);
  import gdad_pkg::*;

  // Stored date
  logic [YearW-1:0]  cur_year_r;
  logic [MonthW-1:0] cur_month_r;
  logic [DayW-1:0]   cur_day_r;
  logic [ModW-1:0]   cur_mod_r;

  // Working registers
  logic [YearW-1:0]  work_year_r;
  logic [ModW-1:0]   work_mod_r;
  logic [MonthW-1:0] work_month_r;
  logic [AccW-1:0]   acc_r;
  logic              err_r;
  logic [YearW-1:0]  ld_year_r;
  logic [MonthW-1:0] ld_month_r;
  logic [DayW-1:0]   ld_day_r;

  // Result register
  logic [YearW-1:0]  res_year_r;
  logic [MonthW-1:0] res_month_r;
  logic [DayW-1:0]   res_day_r;
  status_t           res_stat_r;

  logic [YearW-1:0]  in_year;
  logic [MonthW-1:0] in_month;
  logic [DayW-1:0]   in_day;
  logic [OffW-1:0]   in_off;

  logic [DoyW-1:0]   cur_doy;
  logic              work_leap, prev_leap;
  logic [ModW-1:0]   prev_mod, next_mod;
  logic [DoyW-1:0]   ylen, plen;
  logic [DayW-1:0]   mlen;
  logic              acc_neg;
  logic              ld_leap, ld_ok;

  assign in_year  = in_data[YearLo  +: YearW];
  assign in_month = in_data[MonthLo +: MonthW];
  assign in_day   = in_data[DayLo   +: DayW];
  assign in_off   = in_data[OffLo   +: OffW];

  // Day of year of the stored date, counted from zero.
  assign cur_doy = days_before_month(cur_month_r)
                 + DoyW'(is_leap(cur_mod_r) && (cur_month_r > 4'd2))
                 + DoyW'(cur_day_r) - DoyW'(1);

  assign work_leap = is_leap(work_mod_r);
  assign prev_mod  = (work_mod_r == '0) ? ModW'(399) : work_mod_r - ModW'(1);
  assign next_mod  = (work_mod_r == ModW'(399)) ? '0 : work_mod_r + ModW'(1);
  assign prev_leap = is_leap(prev_mod);
  assign ylen      = year_len(work_leap);
  assign plen      = year_len(prev_leap);
  assign mlen      = month_len(work_month_r, work_leap);
  assign acc_neg   = acc_r[AccW-1];

  // During a load the work year register has been reduced modulo 400.
  assign ld_leap = is_leap(work_year_r[ModW-1:0]);
  assign ld_ok   = (ld_year_r <= YearW'(MaxYear)) &&
                   (ld_month_r >= 4'd1) && (ld_month_r <= 4'd12) &&
                   (ld_day_r != '0) && (ld_day_r <= month_len(ld_month_r, ld_leap));

  always_comb begin
    stat.mod_done   = (work_year_r < YearW'(400));
    stat.year_done  = !acc_neg && (acc_r < AccW'(ylen));
    stat.year_err   = acc_neg ? (work_year_r == '0)
                              : ((acc_r >= AccW'(ylen)) &&
                                 (work_year_r == YearW'(MaxYear)));
    stat.month_done = (work_month_r == 4'd12) || (acc_r < AccW'(mlen));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_year_r  <= '0;
      cur_month_r <= 4'd1;
      cur_day_r   <= 5'd1;
      cur_mod_r   <= '0;
    end else begin
      if (cmd.op == OP_LOAD_END && ld_ok) begin
        cur_year_r  <= ld_year_r;
        cur_month_r <= ld_month_r;
        cur_day_r   <= ld_day_r;
        cur_mod_r   <= work_year_r[ModW-1:0];
      end else if (cmd.add_end && !err_r) begin
        cur_year_r  <= work_year_r;
        cur_month_r <= work_month_r;
        cur_day_r   <= acc_r[DayW-1:0] + DayW'(1);
        cur_mod_r   <= work_mod_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_START: begin
        ld_year_r   <= in_year;
        ld_month_r  <= in_month;
        ld_day_r    <= in_day;
        work_year_r <= in_year;
      end
      OP_MOD_STEP: begin
        work_year_r <= work_year_r - YearW'(400);
      end
      OP_ADD_START: begin
        acc_r        <= {in_off[OffW-1], in_off} + AccW'(cur_doy);
        work_year_r  <= cur_year_r;
        work_mod_r   <= cur_mod_r;
        work_month_r <= 4'd1;
        err_r        <= 1'b0;
      end
      OP_YEAR_STEP: begin
        if (acc_neg) begin
          work_year_r <= work_year_r - YearW'(1);
          work_mod_r  <= prev_mod;
          acc_r       <= acc_r + AccW'(plen);
        end else begin
          work_year_r <= work_year_r + YearW'(1);
          work_mod_r  <= next_mod;
          acc_r       <= acc_r - AccW'(ylen);
        end
      end
      OP_MARK_ERR: begin
        err_r <= 1'b1;
      end
      OP_MONTH_STEP: begin
        acc_r        <= acc_r - AccW'(mlen);
        work_month_r <= work_month_r + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Result register: written with the date the block holds after the item.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_END) begin
      if (ld_ok) begin
        res_year_r  <= ld_year_r;
        res_month_r <= ld_month_r;
        res_day_r   <= ld_day_r;
        res_stat_r  <= ST_OK;
      end else begin
        res_year_r  <= cur_year_r;
        res_month_r <= cur_month_r;
        res_day_r   <= cur_day_r;
        res_stat_r  <= ST_BAD_DATE;
      end
    end else if (cmd.add_end) begin
      if (err_r) begin
        res_year_r  <= cur_year_r;
        res_month_r <= cur_month_r;
        res_day_r   <= cur_day_r;
        res_stat_r  <= ST_RANGE;
      end else begin
        res_year_r  <= work_year_r;
        res_month_r <= work_month_r;
        res_day_r   <= acc_r[DayW-1:0] + DayW'(1);
        res_stat_r  <= ST_OK;
      end
    end
  end

  assign out_data   = {1'b0, res_day_r, res_month_r, res_year_r};
  assign out_status = res_stat_r;

endmodule

// ----- rtl/gregorian_date_add_days_top.sv -----
// ----------------------------------------------------------------------------
// Gregorian date adder
// Keeps one proleptic Gregorian date, loads and validates new dates and moves
// the stored date by a signed number of days.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one beat per item. in_tuser selects the action:
// 0 loads the date in in_tdata and checks it, 1 adds the signed day offset in
// in_tdata to the stored date. Every item returns exactly one result beat
// carrying the stored date after the item, with a status in out_tuser
// (0 ok, 1 invalid date rejected, 2 year range exceeded).
// Items are handled one at a time; in_tready is high only while the block is
// idle. A load reduces the year modulo 400, subtracting 400 once a cycle, and
// then checks the date. An add walks the years (one year a cycle) and then the
// months (one month a cycle).
// The result sits in an output register, so a new item is accepted while a
// result still waits; a stalled receiver holds the beat and the next item
// finishes its work and then waits for the register to empty.
// After reset the stored date is 0000-01-01 and no result is pending.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // bits 13:0 load_year, 17:14 load_month, 22:18 load_day, 39:23 day_offset
  input  logic [gdad_pkg::InDataW-1:0]  in_tdata,
  // bit 0 action
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // bits 13:0 out_year, 17:14 out_month, 22:18 out_day, 23 zero
  output logic [gdad_pkg::OutDataW-1:0] out_tdata,
  // bits 1:0 status
  output logic [gdad_pkg::StatW-1:0]    out_tuser
);
  import gdad_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gdad_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  gdad_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (out_tdata),
    .out_status (out_tuser)
  );

endmodule

// ----- rtl/gdad_checker.sv -----
// ----------------------------------------------------------------------------
// Gregorian date adder checker
// Port-level assertions on the date adder, attached to the top level.
// ----------------------------------------------------------------------------
module gdad_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [gdad_pkg::InDataW-1:0]  in_tdata,
  input logic                          in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [gdad_pkg::OutDataW-1:0] out_tdata,
  input logic [gdad_pkg::StatW-1:0]    out_tuser
);
  import gdad_pkg::*;

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Items are worked one at a time, so the input closes after each beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK) || (out_tuser == ST_BAD_DATE) ||
                   (out_tuser == ST_RANGE))
    else $error("result carries an undefined status");

  // The stored date is always a valid date, whatever the status.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[MonthLo +: MonthW] >= 4'd1) &&
                   (out_tdata[MonthLo +: MonthW] <= 4'd12) &&
                   (out_tdata[DayLo +: DayW] != '0) &&
                   (out_tdata[YearLo +: YearW] <= YearW'(MaxYear)))
    else $error("result date out of range");

endmodule

bind gregorian_date_add_days_top gdad_checker u_gdad_checker (.*);
